// File: design/ggbi_pkg.sv
// package for the geoid grid biquadratic interpolator
// field widths, register indexes, request codes and fixed constants
// no dependencies
package ggbi_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int LON_W      = 31;
  localparam int LAT_W      = 30;
  localparam int SP_W       = 12;
  localparam int CNT_CFG_W  = 9;
  localparam int HGT_W      = 24;
  localparam int IDX_IN_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [HGT_W-1:0] height_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam cfg_idx_t CFG_WEST    = 3'd0;
  localparam cfg_idx_t CFG_SOUTH   = 3'd1;
  localparam cfg_idx_t CFG_COL_SP  = 3'd2;
  localparam cfg_idx_t CFG_ROW_SP  = 3'd3;
  localparam cfg_idx_t CFG_COL_CNT = 3'd4;
  localparam cfg_idx_t CFG_ROW_CNT = 3'd5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  localparam height_t OUTSIDE_HEIGHT = -24'sd999000;
  localparam height_t HEIGHT_MAX     = 24'sd8388607;
  localparam height_t HEIGHT_MIN     = -24'sd8388608;

  localparam logic [SP_W-1:0]      SP_RESET  = 12'd60;
  localparam logic [CNT_CFG_W-1:0] CNT_RESET = 9'd256;

  // spacing in arc-seconds to 1/1024 arc-second units
  localparam int SP_SHIFT = 10;
  // iterations of the fraction division (quotient up to 2^17)
  localparam int FRAC_DIV_K = 18;
  localparam int FRAC_ONE   = 65536;

endpackage

// File: design/ggbi_in_if.sv
// input channel of the geoid grid interpolator: load or query item
// depends on ggbi_pkg
interface ggbi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [ggbi_pkg::IDX_IN_W-1:0]       sample_row;
  logic [ggbi_pkg::IDX_IN_W-1:0]       sample_col;
  logic signed [ggbi_pkg::HGT_W-1:0]   sample_height;
  logic signed [ggbi_pkg::LON_W-1:0]   point_lon;
  logic signed [ggbi_pkg::LAT_W-1:0]   point_lat;

  modport source(output valid, req_type, sample_row, sample_col, sample_height,
                 point_lon, point_lat, input ready);
  modport sink(input valid, req_type, sample_row, sample_col, sample_height,
               point_lon, point_lat, output ready);
endinterface

// File: design/ggbi_out_if.sv
// result channel of the geoid grid interpolator
// depends on ggbi_pkg
interface ggbi_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ggbi_pkg::HGT_W-1:0] height;
  logic                              status;

  modport source(output valid, height, status, input ready);
  modport sink(input valid, height, status, output ready);
endinterface

// File: design/ggbi_cfg_if.sv
// configuration write channel of the geoid grid interpolator
// depends on ggbi_pkg
interface ggbi_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ggbi_pkg::CFG_IDX_W-1:0]     index;
  logic [ggbi_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/ggbi_ram.sv
// single-port ram with registered read
// no dependencies
module ggbi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/geoid_grid_biquadratic_interp_top.sv
// geoid grid biquadratic interpolator, top level
// depends on ggbi_pkg, ggbi_in_if, ggbi_out_if, ggbi_cfg_if, ggbi_ram
//
// usage:
//   in_ch carries items; req_type load writes one height sample into the grid
//   store and gives no result, req_type query gives one result on out_ch.
//   cfg_ch writes the six grid registers (west, south, spacings, counts) and
//   is always ready; write it only while the block is idle.
//   a load leaves the sequencer idle. in a query, two restoring divisions
//   per axis run one quotient bit per cycle on a shared subtractor, nine
//   store reads go through the single ram port, and four quadratic stages
//   go through one shared multiplier, each loading its first value, adding
//   two products and rounding the sum.
//   in_ch.ready is high only while the sequencer is idle.
//   the result sits in an output register; if the receiver stalls, a finished
//   query waits there and the sequencer holds until the register frees.
//   reset clears the sequencer, output valid and the registers to defaults;
//   the grid store is not cleared and must be loaded before it is queried.
module geoid_grid_biquadratic_interp_top #(
  parameter int MAX_COLS = ggbi_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ggbi_pkg::MAX_ROWS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ggbi_in_if.sink   in_ch,
  ggbi_out_if.source out_ch,
  ggbi_cfg_if.sink  cfg_ch
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXN  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int IDX_W = $clog2(MAXN);
  localparam int NW    = $clog2(MAXN + 1);
  localparam int SPD_W = ggbi_pkg::SP_W + ggbi_pkg::SP_SHIFT;
  localparam int D_W   = 32;
  localparam int R_W   = SPD_W + 2;
  localparam int NUM_W = 42;
  localparam int Q_W   = ggbi_pkg::FRAC_DIV_K;
  localparam int MA_W  = Q_W + 1;
  localparam int MB_W  = 40;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 60;
  localparam int G_W   = 36;
  localparam int HH_W  = 18;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LIMX = 4'd1;
  localparam logic [3:0] S_LIMY = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_LOC1 = 4'd4;
  localparam logic [3:0] S_LOC2 = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_HX   = 4'd7;
  localparam logic [3:0] S_HY   = 4'd8;
  localparam logic [3:0] S_HY2  = 4'd9;
  localparam logic [3:0] S_QUAD = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // configuration registers
  logic signed [ggbi_pkg::LON_W-1:0] west_r;
  logic signed [ggbi_pkg::LAT_W-1:0] south_r;
  logic [ggbi_pkg::SP_W-1:0]         colsp_r, rowsp_r;
  logic [ggbi_pkg::CNT_CFG_W-1:0]    colcnt_r, rowcnt_r;

  // sequencer
  logic [3:0]             state_r;
  logic signed [D_W-1:0]  dx_r, dy_r;
  logic                   outx_r;
  logic                   axis_r;
  logic                   phase_r;
  logic [NUM_W-1:0]       rem_r, dsh_r;
  logic [Q_W-1:0]         q_r;
  logic [4:0]             cnt_r;
  logic [IDX_W-1:0]       c0_r, r0_r;
  logic [Q_W-1:0]         tx_r, ty_r;
  logic signed [HH_W-1:0] hx_r, hy_r;
  logic [3:0]             iss_r, cap_ptr_r;
  logic [1:0]             rk_r, rj_r;
  logic                   cap_v_r;
  ggbi_pkg::height_t      samp_r [9];
  logic signed [G_W-1:0]  g_r [3];
  logic [1:0]             qk_r, qs_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [MP_W-1:0] prod_r;
  ggbi_pkg::height_t      res_h_r;
  logic                   res_s_r;
  logic                   out_valid_r;
  ggbi_pkg::height_t      out_height_r;
  logic                   out_status_r;

  // combinational
  logic [NW-1:0]          ncol, nrow, n_sel;
  logic [SPD_W-1:0]       spx, spy, sp_sel;
  logic signed [D_W-1:0]  d_sel;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic                   in_acc, ld_ok, ram_we;
  logic [AW-1:0]          ram_addr, ld_addr, rd_addr;
  ggbi_pkg::height_t      ram_rdata;
  logic                   clamp;
  logic [IDX_W-1:0]       c1, c2;
  logic [R_W-1:0]         r1, r2;
  logic [Q_W-1:0]         t_sel;
  logic signed [HH_W-1:0] h_sel;
  logic signed [G_W-1:0]  f0, f1, f2;
  logic signed [G_W:0]    da;
  logic signed [G_W+1:0]  db;
  logic signed [ACC_W-1:0] prod_ext, rnd8, rnd24;
  logic signed [G_W-1:0]  hv;
  ggbi_pkg::height_t      hsat;
  logic                   lim_x_out, lim_y_out;

  always_comb begin
    if (colcnt_r < 9'd3) begin
      ncol = NW'(3);
    end else if (32'(colcnt_r) > MAX_COLS) begin
      ncol = NW'(MAX_COLS);
    end else begin
      ncol = NW'(colcnt_r);
    end
    if (rowcnt_r < 9'd3) begin
      nrow = NW'(3);
    end else if (32'(rowcnt_r) > MAX_ROWS) begin
      nrow = NW'(MAX_ROWS);
    end else begin
      nrow = NW'(rowcnt_r);
    end
  end

  assign spx = {((colsp_r == '0) ? 12'd1 : colsp_r), 10'b0};
  assign spy = {((rowsp_r == '0) ? 12'd1 : rowsp_r), 10'b0};
  assign n_sel  = axis_r ? nrow : ncol;
  assign sp_sel = axis_r ? spy : spx;
  assign d_sel  = axis_r ? dy_r : dx_r;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign ld_ok  = (32'(in_ch.sample_row) < MAX_ROWS) && (32'(in_ch.sample_col) < MAX_COLS);
  assign ram_we = in_acc && (in_ch.req_type == ggbi_pkg::REQ_LOAD) && ld_ok;
  assign ld_addr = AW'(32'(in_ch.sample_row) * MAX_COLS + 32'(in_ch.sample_col));
  assign rd_addr = AW'((32'(r0_r) + 32'(rk_r)) * MAX_COLS + 32'(c0_r) + 32'(rj_r));
  assign ram_addr = (state_r == S_RD) ? rd_addr : ld_addr;

  ggbi_ram #(.WIDTH(ggbi_pkg::HGT_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.sample_height),
    .rdata (ram_rdata)
  );

  // window location
  always_comb begin
    clamp = 32'(q_r) > (32'(n_sel) - 32'd3);
    c1 = clamp ? IDX_W'(32'(n_sel) - 32'd3) : IDX_W'(q_r);
    r1 = clamp ? R_W'(d_sel - D_W'(prod_r[D_W-1:0])) : R_W'(rem_r);
    if (({r1, 1'b0} < (R_W + 1)'(sp_sel)) && (c1 != '0)) begin
      c2 = c1 - IDX_W'(1);
      r2 = r1 + R_W'(sp_sel);
    end else begin
      c2 = c1;
      r2 = r1;
    end
  end

  // quadratic stage operands
  always_comb begin
    t_sel = (qk_r == 2'd3) ? ty_r : tx_r;
    h_sel = (qk_r == 2'd3) ? hy_r : hx_r;
    case (qk_r)
      2'd0: begin
        f0 = G_W'(samp_r[0]); f1 = G_W'(samp_r[1]); f2 = G_W'(samp_r[2]);
      end
      2'd1: begin
        f0 = G_W'(samp_r[3]); f1 = G_W'(samp_r[4]); f2 = G_W'(samp_r[5]);
      end
      2'd2: begin
        f0 = G_W'(samp_r[6]); f1 = G_W'(samp_r[7]); f2 = G_W'(samp_r[8]);
      end
      default: begin
        f0 = g_r[0]; f1 = g_r[1]; f2 = g_r[2];
      end
    endcase
    da = (G_W + 1)'(f1) - (G_W + 1)'(f0);
    db = ((G_W + 2)'(f2) - (G_W + 2)'(f1)) - (G_W + 2)'(da);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_IDLE: begin
        mul_a = MA_W'(ncol) - MA_W'(1);
        mul_b = MB_W'(spx);
      end
      S_LIMX: begin
        mul_a = MA_W'(nrow) - MA_W'(1);
        mul_b = MB_W'(spy);
      end
      S_LOC1: begin
        mul_a = MA_W'(n_sel) - MA_W'(3);
        mul_b = MB_W'(sp_sel);
      end
      S_HX: begin
        mul_a = $signed({1'b0, tx_r});
        mul_b = $signed(MB_W'(tx_r)) - MB_W'(ggbi_pkg::FRAC_ONE);
      end
      S_HY: begin
        mul_a = $signed({1'b0, ty_r});
        mul_b = $signed(MB_W'(ty_r)) - MB_W'(ggbi_pkg::FRAC_ONE);
      end
      S_QUAD: begin
        if (qs_r == 2'd0) begin
          mul_a = $signed({1'b0, t_sel});
          mul_b = MB_W'(da);
        end else begin
          mul_a = MA_W'(h_sel);
          mul_b = MB_W'(db);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);
  assign rnd8  = acc_r + ACC_W'(128);
  assign rnd24 = acc_r + ACC_W'(8388608);
  assign hv    = rnd24[24 +: G_W];

  always_comb begin
    if (hv > G_W'(ggbi_pkg::HEIGHT_MAX)) begin
      hsat = ggbi_pkg::HEIGHT_MAX;
    end else if (hv < G_W'(ggbi_pkg::HEIGHT_MIN)) begin
      hsat = ggbi_pkg::HEIGHT_MIN;
    end else begin
      hsat = hv[ggbi_pkg::HGT_W-1:0];
    end
  end

  assign lim_x_out = (dx_r <= 0) || (MP_W'(dx_r) >= prod_r);
  assign lim_y_out = (dy_r <= 0) || (MP_W'(dy_r) >= prod_r);

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_r   <= '0;
      south_r  <= '0;
      colsp_r  <= ggbi_pkg::SP_RESET;
      rowsp_r  <= ggbi_pkg::SP_RESET;
      colcnt_r <= ggbi_pkg::CNT_RESET;
      rowcnt_r <= ggbi_pkg::CNT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ggbi_pkg::CFG_WEST:    west_r   <= cfg_ch.data[ggbi_pkg::LON_W-1:0];
        ggbi_pkg::CFG_SOUTH:   south_r  <= cfg_ch.data[ggbi_pkg::LAT_W-1:0];
        ggbi_pkg::CFG_COL_SP:  colsp_r  <= cfg_ch.data[ggbi_pkg::SP_W-1:0];
        ggbi_pkg::CFG_ROW_SP:  rowsp_r  <= cfg_ch.data[ggbi_pkg::SP_W-1:0];
        ggbi_pkg::CFG_COL_CNT: colcnt_r <= cfg_ch.data[ggbi_pkg::CNT_CFG_W-1:0];
        ggbi_pkg::CFG_ROW_CNT: rowcnt_r <= cfg_ch.data[ggbi_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.height = out_height_r;
  assign out_ch.status = out_status_r;

  // payload and datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dx_r <= D_W'(in_ch.point_lon) - D_W'(west_r);
          dy_r <= D_W'(in_ch.point_lat) - D_W'(south_r);
        end
      end
      S_LIMX: outx_r <= lim_x_out;
      S_LIMY: begin
        res_h_r <= ggbi_pkg::OUTSIDE_HEIGHT;
        res_s_r <= ggbi_pkg::ST_OUTSIDE;
        axis_r  <= 1'b0;
        phase_r <= 1'b0;
        rem_r   <= NUM_W'(dx_r);
        dsh_r   <= NUM_W'(spx) << (IDX_W - 1);
        q_r     <= '0;
        cnt_r   <= 5'(IDX_W);
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[Q_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[Q_W-2:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 5'd1;
        end else if (phase_r) begin
          if (!axis_r) begin
            // fraction of x done, start y cell division
            tx_r    <= q_r;
            axis_r  <= 1'b1;
            phase_r <= 1'b0;
            rem_r   <= NUM_W'(dy_r);
            dsh_r   <= NUM_W'(spy) << (IDX_W - 1);
            q_r     <= '0;
            cnt_r   <= 5'(IDX_W);
          end else begin
            ty_r    <= q_r;
            iss_r   <= '0;
            rk_r    <= '0;
            rj_r    <= '0;
            cap_v_r <= 1'b0;
          end
        end
      end
      S_LOC2: begin
        if (axis_r) begin
          r0_r <= c2;
        end else begin
          c0_r <= c2;
        end
        phase_r <= 1'b1;
        rem_r   <= (NUM_W'(r2) << 17) + NUM_W'(sp_sel);
        dsh_r   <= NUM_W'(sp_sel) << (ggbi_pkg::FRAC_DIV_K);
        q_r     <= '0;
        cnt_r   <= 5'(ggbi_pkg::FRAC_DIV_K);
      end
      S_RD: begin
        if (iss_r < 4'd9) begin
          iss_r <= iss_r + 4'd1;
          if (rj_r == 2'd2) begin
            rj_r <= '0;
            rk_r <= rk_r + 2'd1;
          end else begin
            rj_r <= rj_r + 2'd1;
          end
        end
        cap_v_r   <= (iss_r < 4'd9);
        cap_ptr_r <= iss_r;
        if (cap_v_r) begin
          samp_r[cap_ptr_r] <= ram_rdata;
        end
        qk_r <= '0;
        qs_r <= '0;
      end
      S_HY:  hx_r <= HH_W'((prod_ext + ACC_W'(65536)) >>> 17);
      S_HY2: hy_r <= HH_W'((prod_ext + ACC_W'(65536)) >>> 17);
      S_QUAD: begin
        case (qs_r)
          2'd0: begin
            acc_r <= ACC_W'(f0) <<< 16;
            qs_r  <= 2'd1;
          end
          2'd1: begin
            acc_r <= acc_r + prod_ext;
            qs_r  <= 2'd2;
          end
          2'd2: begin
            acc_r <= acc_r + prod_ext;
            qs_r  <= 2'd3;
          end
          default: begin
            if (qk_r != 2'd3) begin
              g_r[qk_r] <= rnd8[8 +: G_W];
            end else begin
              res_h_r <= hsat;
              res_s_r <= ggbi_pkg::ST_OK;
            end
            qk_r <= qk_r + 2'd1;
            qs_r <= 2'd0;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_height_r <= res_h_r;
          out_status_r <= res_s_r;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.req_type == ggbi_pkg::REQ_QUERY)) begin
            state_r <= S_LIMX;
          end
        end
        S_LIMX: state_r <= S_LIMY;
        S_LIMY: state_r <= (outx_r || lim_y_out) ? S_DONE : S_DIV;
        S_DIV: begin
          if (cnt_r == '0) begin
            if (!phase_r) begin
              state_r <= S_LOC1;
            end else if (axis_r) begin
              state_r <= S_RD;
            end
          end
        end
        S_LOC1: state_r <= S_LOC2;
        S_LOC2: state_r <= S_DIV;
        S_RD: begin
          if (cap_v_r && (cap_ptr_r == 4'd8)) begin
            state_r <= S_HX;
          end
        end
        S_HX:  state_r <= S_HY;
        S_HY:  state_r <= S_HY2;
        S_HY2: state_r <= S_QUAD;
        S_QUAD: begin
          if ((qs_r == 2'd3) && (qk_r == 2'd3)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("grid store written while a query is in progress");

  a_outside_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ggbi_pkg::ST_OUTSIDE))
      |-> (out_height_r == ggbi_pkg::OUTSIDE_HEIGHT))
    else $error("outside result without sentinel height");

  a_window_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HX) |-> ((32'(c0_r) <= 32'(ncol) - 32'd3)
                          && (32'(r0_r) <= 32'(nrow) - 32'd3)))
    else $error("3x3 window runs past the grid edge");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HX) |-> ((32'(tx_r) <= 32'd131072) && (32'(ty_r) <= 32'd131072)))
    else $error("fraction above two");

endmodule
